@@ hdl/lcdns_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lcdns_pkg;

  // Request codes on in_command
  typedef enum logic [1:0] {
    CMD_INIT       = 2'd0,
    CMD_WR_CMD     = 2'd1,
    CMD_WR_DATA    = 2'd2,
    CMD_SET_CURSOR = 2'd3
  } cmd_t;

  // Work handed from front to back
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
  } job_t;

  // One pin-state segment
  typedef struct packed {
    logic       reg_select;
    logic       enable;
    logic [3:0] bus_nibble;
    logic [4:0] hold_ms;
  } seg_t;

  localparam int STEP_W      = 5;
  localparam int INIT_STEPS  = 25;
  localparam int BYTE_STEPS  = 4;
  localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_STEPS - 1);
  localparam logic [STEP_W-1:0] BYTE_LAST = STEP_W'(BYTE_STEPS - 1);
  localparam logic [STEP_W-1:0] INIT_BYTE_START = STEP_W'(9);

  // Job queue, depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [3:0] HELD_RESET   = 4'hF;
  localparam logic [4:0] POWERUP_MS   = 5'd20;
  localparam logic [4:0] PULSE_MS     = 5'd1;
  localparam logic [4:0] BYTE_TAIL_MS = 5'd3;
  localparam logic [3:0] WAKE_NIB     = 4'h3;
  localparam logic [3:0] MODE4_NIB    = 4'h2;

  // Set-up bytes after wake-up: function set, display on, entry mode, clear
  localparam logic [3:0][7:0] INIT_BYTES = {8'h01, 8'h06, 8'h0C, 8'h28};
  // Low-phase hold of the four wake-up nibbles
  localparam logic [3:0][4:0] WAKE_LOW_MS = {5'd1, 5'd2, 5'd2, 5'd6};

  // Segment w of a byte transfer: hi pulse, hi low, lo pulse, lo low + settle
  function automatic seg_t byte_seg(input logic rs, input logic [7:0] b,
                                    input logic [1:0] w);
    seg_t s;
    s.reg_select = rs;
    s.enable     = ~w[0];
    s.bus_nibble = w[1] ? b[3:0] : b[7:4];
    s.hold_ms    = (w == 2'd3) ? BYTE_TAIL_MS : PULSE_MS;
    return s;
  endfunction

  function automatic seg_t init_seg(input logic [STEP_W-1:0] step,
                                    input logic [3:0] held);
    seg_t s;
    logic [STEP_W-1:0] k;
    logic [STEP_W-1:0] j;
    k = step - STEP_W'(1);
    j = step - INIT_BYTE_START;
    if (step == '0) begin
      s.reg_select = 1'b0;
      s.enable     = 1'b0;
      s.bus_nibble = held;
      s.hold_ms    = POWERUP_MS;
    end else if (step < INIT_BYTE_START) begin
      s.reg_select = 1'b0;
      s.enable     = ~k[0];
      s.bus_nibble = (k[2:1] == 2'd3) ? MODE4_NIB : WAKE_NIB;
      s.hold_ms    = k[0] ? WAKE_LOW_MS[k[2:1]] : PULSE_MS;
    end else begin
      s = byte_seg(1'b0, INIT_BYTES[j[3:2]], j[1:0]);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/char_lcd_nibble_sequencer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Character LCD 4-bit nibble sequencer.
// Input queue: drive in_command/in_byte_value/in_column/in_row with in_push;
// an item is taken on a clock edge with in_push high and in_full low.
// Commands: initialize, write command byte, write data byte, set cursor.
// Result queue: while out_empty is low the oldest segment (RS, E, nibble,
// hold time in ms, last flag) sits on the out_ ports; out_pop takes it.
// Path: the first segment of a request passes through the job queue and
// then the output register before it shows on the out_ ports.
// Throughput: one segment per cycle from the back sequencer while the output
// is drained; a byte request is 4 segments and initialize 25. A two-entry
// job queue decouples the front, so requests are taken while segments drain.
// If the receiver stalls, the output register holds its segment, the
// sequencer stops, and the queue fills until in_full rises.
// Reset (rst_n low, synchronous) empties both queues, restarts the
// sequencer and sets the remembered bus nibble to all ones.
module char_lcd_nibble_sequencer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_byte_value,
  input  wire logic [5:0] in_column,
  input  wire logic       in_row,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic            out_reg_select,
  output logic            out_enable,
  output logic [3:0]      out_bus_nibble,
  output logic [4:0]      out_hold_ms,
  output logic            out_last
);

  lcdns_pkg::job_t new_job;
  lcdns_pkg::job_t head_job;
  logic            head_valid;
  logic            head_pop;
  lcdns_pkg::seg_t seg;

  // Front: classify the request
  lcdns_front u_front (
    .command    (in_command),
    .byte_value (in_byte_value),
    .column     (in_column),
    .row        (in_row),
    .job_o      (new_job)
  );

  // Short queue between front and back
  lcdns_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_push),
    .wr_job    (new_job),
    .full      (in_full),
    .rd_en     (head_pop),
    .rd_job    (head_job),
    .not_empty (head_valid)
  );

  // Back: segment sequencer and output register
  lcdns_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_i       (head_job),
    .job_valid_i (head_valid),
    .job_pop_o   (head_pop),
    .out_seg_o   (seg),
    .out_last_o  (out_last),
    .out_empty_o (out_empty),
    .out_pop_i   (out_pop)
  );

  assign out_reg_select = seg.reg_select;
  assign out_enable     = seg.enable;
  assign out_bus_nibble = seg.bus_nibble;
  assign out_hold_ms    = seg.hold_ms;

endmodule

`default_nettype wire

@@ hdl/lcdns_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Turns a request into a job: init flag, RS level and byte to send.
module lcdns_front (
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  byte_value,
  input  wire logic [5:0]  column,
  input  wire logic        row,
  output lcdns_pkg::job_t  job_o
);

  always_comb begin
    job_o = '0;
    unique case (lcdns_pkg::cmd_t'(command))
      lcdns_pkg::CMD_INIT: begin
        job_o.is_init = 1'b1;
      end
      lcdns_pkg::CMD_WR_CMD: begin
        job_o.data = byte_value;
      end
      lcdns_pkg::CMD_WR_DATA: begin
        job_o.rs   = 1'b1;
        job_o.data = byte_value;
      end
      lcdns_pkg::CMD_SET_CURSOR: begin
        // 0x80 + col or 0xC0 + col; col < 64 so no carry
        job_o.data = {1'b1, row, column};
      end
      default: job_o = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/lcdns_job_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lcdns_job_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire lcdns_pkg::job_t wr_job,
  output logic                 full,
  input  wire logic            rd_en,
  output lcdns_pkg::job_t      rd_job,
  output logic                 not_empty
);

  lcdns_pkg::job_t mem_r [lcdns_pkg::QUEUE_DEPTH];
  logic [lcdns_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lcdns_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lcdns_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_wr, do_rd;

  assign full      = (count_r == lcdns_pkg::QCNT_W'(lcdns_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_job    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + lcdns_pkg::QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - lcdns_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lcdns_pkg::QCNT_W'(lcdns_pkg::QUEUE_DEPTH))
    else $error("job queue count overflow");

endmodule

`default_nettype wire

@@ hdl/lcdns_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Unless stalled, walks head job one segment per cycle into a one-entry reg.
module lcdns_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lcdns_pkg::job_t job_i,
  input  wire logic            job_valid_i,
  output logic                 job_pop_o,
  output lcdns_pkg::seg_t      out_seg_o,
  output logic                 out_last_o,
  output logic                 out_empty_o,
  input  wire logic            out_pop_i
);

  logic [lcdns_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [3:0]      held_r;
  logic            out_valid_r;
  lcdns_pkg::seg_t out_seg_r;
  logic            out_last_r;
  lcdns_pkg::seg_t seg;
  logic            seg_last;
  logic            advance;

  always_comb begin
    if (job_i.is_init) begin
      seg      = lcdns_pkg::init_seg(step_r, held_r);
      seg_last = (step_r == lcdns_pkg::INIT_LAST);
    end else begin
      seg      = lcdns_pkg::byte_seg(job_i.rs, job_i.data, step_r[1:0]);
      seg_last = (step_r == lcdns_pkg::BYTE_LAST);
    end
    // Next segment moves in when the output slot is free or being drained
    advance   = job_valid_i && (!out_valid_r || out_pop_i);
    job_pop_o = advance && seg_last;
    step_nxt  = step_r;
    if (advance) begin
      step_nxt = seg_last ? '0 : step_r + lcdns_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      held_r      <= lcdns_pkg::HELD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
        held_r      <= seg.bus_nibble;
      end else if (out_pop_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_seg_r  <= seg;
      out_last_r <= seg_last;
    end
  end

  assign out_seg_o   = out_seg_r;
  assign out_last_o  = out_last_r;
  assign out_empty_o = !out_valid_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= lcdns_pkg::INIT_LAST)
    else $error("step counter out of range");

  a_byte_step: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid_i && !job_i.is_init) |-> (step_r <= lcdns_pkg::BYTE_LAST))
    else $error("byte job step out of range");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop_o |=> (step_r == '0) && !out_empty_o && out_last_o)
    else $error("job end did not restart sequencer");

endmodule

`default_nettype wire
